FILE: hdl/magcal_pkg.sv
// Shared constants, types and helpers for the magnetometer min/max calibration core.
package magcal_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 14;
    localparam int IN_W          = 16;
    localparam int OUT_W         = 16;
    localparam int AXES          = 3;
    localparam int QUO_W         = FRACTION_BITS + 1;
    localparam int STEP_W        = $clog2(QUO_W);
    localparam int SAT_W         = (FRACTION_BITS + 2 > OUT_W) ? FRACTION_BITS + 2 : OUT_W;

    typedef struct packed {
        logic load;
        logic prep;
        logic step;
        logic first;
        logic capture;
    } t_cmd;

    function automatic logic signed [SAMPLE_BITS-1:0] widen(input logic [IN_W-1:0] raw);
        logic [SAMPLE_BITS+IN_W-1:0] ext;
        ext = {{SAMPLE_BITS{1'b0}}, raw};
        return signed'(ext[SAMPLE_BITS-1:0]);
    endfunction

endpackage

FILE: hdl/magcal_ctrl.sv
// Sequencer: request handshakes, divider step count and output valid.
module magcal_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output magcal_pkg::t_cmd  o_cmd
);
    import magcal_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [STEP_W-1:0]  r_cnt;
    logic               r_valid;
    logic               v_out_free;

    assign v_out_free  = !r_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_valid;

    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = i_in_valid && (r_state == S_IDLE);
        o_cmd.prep    = (r_state == S_PREP);
        o_cmd.step    = (r_state == S_DIV);
        o_cmd.first   = (r_cnt == '0);
        o_cmd.capture = (r_state == S_DONE) && v_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_PREP;
                end
                S_PREP: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == STEP_W'(FRACTION_BITS)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    if (v_out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_cmd.capture) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: hdl/magcal_datapath.sv
// Per-axis min/max tracking, numerator/range setup, restoring divider and saturation.
module magcal_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  magcal_pkg::t_cmd               i_cmd,
    input  logic [magcal_pkg::IN_W-1:0]    i_mag_x,
    input  logic [magcal_pkg::IN_W-1:0]    i_mag_y,
    input  logic [magcal_pkg::IN_W-1:0]    i_mag_z,
    output logic [magcal_pkg::OUT_W-1:0]   o_norm_x,
    output logic [magcal_pkg::OUT_W-1:0]   o_norm_y,
    output logic [magcal_pkg::OUT_W-1:0]   o_norm_z
);
    import magcal_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(2 ** (OUT_W - 1) - 1);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

    logic [IN_W-1:0]  v_raw [AXES];
    logic [OUT_W-1:0] v_out [AXES];

    assign v_raw[0] = i_mag_x;
    assign v_raw[1] = i_mag_y;
    assign v_raw[2] = i_mag_z;
    assign o_norm_x = v_out[0];
    assign o_norm_y = v_out[1];
    assign o_norm_z = v_out[2];

    for (genvar g = 0; g < AXES; g++) begin : g_axis
        logic signed [SB-1:0]    r_min;
        logic signed [SB-1:0]    r_max;
        logic signed [SB-1:0]    r_sample;
        logic [SB-1:0]           r_den;
        logic [SB:0]             r_rem;
        logic [QUO_W-1:0]        r_quo;
        logic                    r_neg;
        logic [OUT_W-1:0]        r_out;

        logic signed [SB-1:0]    v_s;
        logic signed [SB+1:0]    v_num;
        logic [SB+1:0]           v_mag;
        logic [SB:0]             v_den_w;
        logic [SB-1:0]           v_den;
        logic [SB:0]             v_trial;
        logic                    v_ge;
        logic signed [SAT_W-1:0] v_q;
        logic [OUT_W-1:0]        v_sat;

        assign v_s = widen(v_raw[g]);

        always_comb begin
            v_num   = (SB+2)'(r_sample) + (SB+2)'(r_sample) - (SB+2)'(r_min) - (SB+2)'(r_max);
            v_mag   = v_num[SB+1] ? -v_num : v_num;
            v_den_w = (SB+1)'(r_max) - (SB+1)'(r_min);
            v_den   = (v_den_w[SB-1:0] == '0) ? SB'(1) : v_den_w[SB-1:0];
        end

        always_comb begin
            v_trial = i_cmd.first ? r_rem : {r_rem[SB-1:0], 1'b0};
            v_ge    = (v_trial >= {1'b0, r_den});
        end

        always_comb begin
            v_q = SAT_W'(signed'({1'b0, r_quo}));
            if (r_neg) v_q = -v_q;
            if (v_q > SAT_HI) begin
                v_sat = OUT_W'(SAT_HI);
            end else if (v_q < SAT_LO) begin
                v_sat = OUT_W'(SAT_LO);
            end else begin
                v_sat = OUT_W'(v_q);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_min <= '0;
                r_max <= '0;
            end else if (i_cmd.load) begin
                if (v_s < r_min) r_min <= v_s;
                if (v_s > r_max) r_max <= v_s;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.load) r_sample <= v_s;
            if (i_cmd.prep) begin
                r_den <= v_den;
                r_rem <= {1'b0, v_mag[SB-1:0]};
                r_neg <= v_num[SB+1];
                r_quo <= '0;
            end
            if (i_cmd.step) begin
                r_rem <= v_ge ? v_trial - {1'b0, r_den} : v_trial;
                r_quo <= {r_quo[QUO_W-2:0], v_ge};
            end
            if (i_cmd.capture) r_out <= v_sat;
        end

        assign v_out[g] = r_out;
    end

endmodule

FILE: hdl/magnetometer_minmax_calibration_core.sv
// Top level of the magnetometer min/max hard-iron calibration core.
// Each accepted request carries one X/Y/Z sample. Every axis widens its running
// min/max (both zero after reset) to hold the sample, then returns
// (2*sample - min - max) / (max - min) in signed Q1.14, truncated toward zero.
// An item passes through an accept state, a setup state, FRACTION_BITS+1 = 15 steps
// of a one-bit-per-cycle restoring divider (one per axis, all three in parallel)
// and a load of the output register, which waits until the previous result is taken.
// A finished result waits in the output register without blocking the next request.
module magnetometer_minmax_calibration_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [magcal_pkg::IN_W-1:0]   i_mag_x,
    input  logic [magcal_pkg::IN_W-1:0]   i_mag_y,
    input  logic [magcal_pkg::IN_W-1:0]   i_mag_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [magcal_pkg::OUT_W-1:0]  o_norm_x,
    output logic [magcal_pkg::OUT_W-1:0]  o_norm_y,
    output logic [magcal_pkg::OUT_W-1:0]  o_norm_z
);
    import magcal_pkg::*;

    t_cmd w_cmd;

    magcal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    magcal_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_mag_x  (i_mag_x),
        .i_mag_y  (i_mag_y),
        .i_mag_z  (i_mag_z),
        .o_norm_x (o_norm_x),
        .o_norm_y (o_norm_y),
        .o_norm_z (o_norm_z)
    );

endmodule

FILE: hdl/magcal_checker.sv
// Port-level checks for the calibration core, bound to the top level.
module magcal_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [magcal_pkg::OUT_W-1:0]  o_norm_x,
    input logic [magcal_pkg::OUT_W-1:0]  o_norm_y,
    input logic [magcal_pkg::OUT_W-1:0]  o_norm_z
);
    import magcal_pkg::*;

    localparam int QLIM = (2 ** FRACTION_BITS > 2 ** (OUT_W - 1) - 1) ?
                          2 ** (OUT_W - 1) - 1 : 2 ** FRACTION_BITS;

    logic w_in_acc;
    logic w_in_range;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_in_range =
        (int'($signed(o_norm_x)) <= QLIM) && (int'($signed(o_norm_x)) >= -QLIM - 1) &&
        (int'($signed(o_norm_y)) <= QLIM) && (int'($signed(o_norm_y)) >= -QLIM - 1) &&
        (int'($signed(o_norm_z)) <= QLIM) && (int'($signed(o_norm_z)) >= -QLIM - 1);

    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("ready stayed high after a request was taken");

    a_result_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> w_in_range)
        else $error("normalized result outside +/-1.0");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_norm_x) && $stable(o_norm_y) && $stable(o_norm_z))
        else $error("stalled result dropped or changed");

endmodule

bind magnetometer_minmax_calibration_core magcal_checker u_magcal_checker (.*);
